### design/hash_insert_distinct_chained_unit_defines.svh
// assertion macros used by the checker file
`ifndef HASH_INSERT_DISTINCT_CHAINED_UNIT_DEFINES_SVH
`define HASH_INSERT_DISTINCT_CHAINED_UNIT_DEFINES_SVH

// condition must never hold while out of reset
`define HIDC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("check failed: never");

// same-cycle implication
`define HIDC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: implication");

// next-cycle implication
`define HIDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next cycle");

`endif

### design/hidc_pkg.sv
// shared constants, types and codes of the chained hash insert unit
`default_nettype none
package hidc_pkg;
    localparam int MaxSlots  = 2048;
    localparam int MaxNodes  = 1024;
    localparam int SlotW     = $clog2(MaxSlots);
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int CntW      = NodeW + 1;
    localparam int KeyW      = 31;
    localparam int CfgW      = 20;
    localparam int SlotsW    = 12;
    localparam int ProdW     = 52;
    localparam int StepW     = 5;
    localparam int BktW      = 1 + 2 * NodeW;
    localparam int FoldMulW  = 16;
    localparam int FoldW     = ProdW - CfgW + FoldMulW;
    localparam logic [CfgW-1:0] HashPrime = 20'd999149;
    // 2^20 mod 999149, weight of the bits above the low 20 when folding
    localparam logic [FoldMulW-1:0] HashFold = 16'd49427;

    typedef enum logic [1:0] {
        CFG_NUM_SLOTS = 2'd0,
        CFG_HASH_MULT = 2'd1,
        CFG_HASH_ADD  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MUL,
        ST_MODP,
        ST_MODS,
        ST_BRD,
        ST_HCHK,
        ST_NRD,
        ST_NCMP,
        ST_INS,
        ST_LINK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic mul;
        logic modp;
        logic mods;
        logic head_chk;
        logic node_cmp;
        logic ins;
        logic link;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic fold_done;
        logic clr_done;
        logic bkt_valid;
        logic link_valid;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

### design/hidc_ctrl.sv
// sequencing state machine of the chained hash insert unit
`default_nettype none
module hidc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  hidc_pkg::t_status    i_status,
    output logic                 o_in_ready,
    output hidc_pkg::t_cmd       o_cmd
);
    hidc_pkg::t_state r_state;
    hidc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hidc_pkg::ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hidc_pkg::ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_done) n_state = hidc_pkg::ST_IDLE;
            end
            hidc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = hidc_pkg::ST_MUL;
                end
            end
            hidc_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = hidc_pkg::ST_MODP;
            end
            hidc_pkg::ST_MODP: begin
                o_cmd.modp = 1'b1;
                if (i_status.fold_done) n_state = hidc_pkg::ST_MODS;
            end
            hidc_pkg::ST_MODS: begin
                o_cmd.mods = 1'b1;
                if (i_status.cnt_zero) n_state = hidc_pkg::ST_BRD;
            end
            hidc_pkg::ST_BRD: begin
                n_state = hidc_pkg::ST_HCHK;
            end
            hidc_pkg::ST_HCHK: begin
                o_cmd.head_chk = 1'b1;
                n_state = i_status.bkt_valid ? hidc_pkg::ST_NRD : hidc_pkg::ST_INS;
            end
            hidc_pkg::ST_NRD: begin
                n_state = hidc_pkg::ST_NCMP;
            end
            hidc_pkg::ST_NCMP: begin
                o_cmd.node_cmp = 1'b1;
                n_state = i_status.link_valid ? hidc_pkg::ST_NRD : hidc_pkg::ST_INS;
            end
            hidc_pkg::ST_INS: begin
                o_cmd.ins = 1'b1;
                n_state = hidc_pkg::ST_LINK;
            end
            hidc_pkg::ST_LINK: begin
                o_cmd.link = 1'b1;
                n_state = hidc_pkg::ST_FIN;
            end
            hidc_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = hidc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hidc_pkg::ST_CLR;
            end
        endcase
    end
endmodule
`default_nettype wire

### design/hidc_dp.sv
// datapath: hash reduction, bucket and node stores, statistics, result register
`default_nettype none
module hidc_dp (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [1:0]                     i_cfg_idx,
    input  wire  [hidc_pkg::CfgW-1:0]      i_cfg_data,
    input  wire  [hidc_pkg::KeyW-1:0]      i_key,
    input  hidc_pkg::t_cmd                 i_cmd,
    output hidc_pkg::t_status              o_status,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output logic [hidc_pkg::SlotW-1:0]     o_bucket,
    output logic                           o_inserted,
    output logic                           o_table_full,
    output logic [hidc_pkg::CntW-1:0]      o_chain_length,
    output logic [hidc_pkg::CntW-1:0]      o_collisions,
    output logic [hidc_pkg::CntW-1:0]      o_longest_chain,
    output logic [hidc_pkg::CntW-1:0]      o_stored_keys
);
    localparam int SlotW = hidc_pkg::SlotW;
    localparam int NodeW = hidc_pkg::NodeW;
    localparam int CntW  = hidc_pkg::CntW;
    localparam int KeyW  = hidc_pkg::KeyW;
    localparam int CfgW  = hidc_pkg::CfgW;
    localparam int SlW   = hidc_pkg::SlotsW;
    localparam int ProdW = hidc_pkg::ProdW;
    localparam int StepW = hidc_pkg::StepW;
    localparam int BktW  = hidc_pkg::BktW;
    localparam int FoldW = hidc_pkg::FoldW;

    // configuration
    logic [SlW-1:0]  r_num_slots;
    logic [CfgW-1:0] r_hash_mult;
    logic [CfgW-1:0] r_hash_add;

    // working registers
    logic [KeyW-1:0]  r_key;
    logic [ProdW-1:0] r_prod;
    logic [CfgW-1:0]  r_rem_p;
    logic [SlotW-1:0] r_rem_s;
    logic [SlotW-1:0] r_bucket;
    logic [StepW-1:0] r_cnt;
    logic [SlotW-1:0] r_clr_addr;
    logic [NodeW-1:0] r_cur;
    logic [CntW-1:0]  r_len;
    logic             r_found;
    logic             r_ins;
    logic             r_full;
    logic             r_hvalid;
    logic [NodeW-1:0] r_head;
    logic [NodeW-1:0] r_tail;
    logic             r_append;
    logic [CntW-1:0]  r_nodes_used;
    logic [CntW-1:0]  r_coll;
    logic [CntW-1:0]  r_max;
    logic             r_out_valid;

    // stores
    logic [BktW-1:0]  bkt_mem [hidc_pkg::MaxSlots];
    logic [KeyW-1:0]  key_mem [hidc_pkg::MaxNodes];
    logic [NodeW:0]   link_mem [hidc_pkg::MaxNodes];
    logic [BktW-1:0]  r_bkt_rd;
    logic [KeyW-1:0]  r_key_rd;
    logic [NodeW:0]   r_link_rd;

    logic [SlW-1:0]   eff_slots;
    logic [FoldW-1:0] fold_p;
    logic [ProdW-1:0] fold_n;
    logic             fold_done;
    logic [SlW-1:0]   mods_t;
    logic [CfgW-1:0]  modp_n;
    logic [SlotW-1:0] mods_n;
    logic [NodeW-1:0] new_node;
    logic             can_store;
    logic [CntW-1:0]  len_cmp;

    always_comb begin
        eff_slots = r_num_slots;
        if (r_num_slots == '0) eff_slots = SlW'(1);
        if (r_num_slots > SlW'(hidc_pkg::MaxSlots)) eff_slots = SlW'(hidc_pkg::MaxSlots);
        // fold the bits above the low 20 back in, weighted by 2^20 mod prime
        fold_p    = FoldW'(r_prod[ProdW-1:CfgW]) * FoldW'(hidc_pkg::HashFold);
        fold_n    = ProdW'(fold_p) + ProdW'(r_prod[CfgW-1:0]);
        fold_done = (r_prod[ProdW-1:CfgW] == '0);
        // low 20 bits are below twice the prime, one subtract finishes
        modp_n = (r_prod[CfgW-1:0] >= hidc_pkg::HashPrime)
               ? r_prod[CfgW-1:0] - hidc_pkg::HashPrime : r_prod[CfgW-1:0];
        mods_t = {r_rem_s, r_rem_p[CfgW-1]};
        mods_n = (mods_t >= eff_slots) ? SlotW'(mods_t - eff_slots) : SlotW'(mods_t);
        new_node  = r_nodes_used[NodeW-1:0];
        can_store = !r_found && !r_nodes_used[CntW-1];
        len_cmp   = r_len + CntW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_slots <= SlW'(hidc_pkg::MaxSlots);
            r_hash_mult <= CfgW'(1);
            r_hash_add  <= '0;
        end else if (i_cfg_we) begin
            case (hidc_pkg::t_cfg_idx'(i_cfg_idx))
                hidc_pkg::CFG_NUM_SLOTS: r_num_slots <= i_cfg_data[SlW-1:0];
                hidc_pkg::CFG_HASH_MULT: r_hash_mult <= i_cfg_data;
                hidc_pkg::CFG_HASH_ADD:  r_hash_add  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_nodes_used <= '0;
            r_coll       <= '0;
            r_max        <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + SlotW'(1);
            if (i_cmd.mul) r_cnt <= StepW'(CfgW - 1);
            if (i_cmd.mods) r_cnt <= r_cnt - StepW'(1);
            if (i_cmd.ins && can_store) begin
                r_nodes_used <= r_nodes_used + CntW'(1);
                if (r_hvalid) r_coll <= r_coll + CntW'(1);
            end
            if (i_cmd.fin && r_len > r_max) r_max <= r_len;
            if (i_cmd.fin) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key   <= i_key;
            r_found <= 1'b0;
            r_ins   <= 1'b0;
            r_full  <= 1'b0;
            r_len   <= '0;
        end
        if (i_cmd.mul) begin
            r_prod  <= ProdW'(r_hash_mult) * ProdW'(r_key) + ProdW'(r_hash_add);
            r_rem_p <= '0;
            r_rem_s <= '0;
        end
        if (i_cmd.modp) begin
            if (fold_done) r_rem_p <= modp_n;
            else r_prod <= fold_n;
        end
        if (i_cmd.mods) begin
            r_rem_s <= mods_n;
            r_rem_p <= {r_rem_p[CfgW-2:0], 1'b0};
            if (r_cnt == '0) r_bucket <= mods_n;
        end
        if (i_cmd.head_chk) begin
            r_hvalid <= r_bkt_rd[BktW-1];
            r_head   <= r_bkt_rd[2*NodeW-1:NodeW];
            r_tail   <= r_bkt_rd[NodeW-1:0];
            r_cur    <= r_bkt_rd[2*NodeW-1:NodeW];
        end
        if (i_cmd.node_cmp) begin
            r_len <= len_cmp;
            if (r_key_rd == r_key) r_found <= 1'b1;
            r_cur <= r_link_rd[NodeW-1:0];
        end
        if (i_cmd.ins) begin
            r_append <= can_store && r_hvalid;
            if (can_store) begin
                r_ins <= 1'b1;
                r_len <= len_cmp;
            end else if (!r_found) begin
                r_full <= 1'b1;
            end
        end
        if (i_cmd.fin) begin
            o_bucket       <= r_bucket;
            o_inserted     <= r_ins;
            o_table_full   <= r_full;
            o_chain_length <= r_len;
            o_collisions   <= r_coll;
            o_longest_chain <= (r_len > r_max) ? r_len : r_max;
            o_stored_keys  <= r_nodes_used;
        end
    end

    // bucket store: valid, head, tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            bkt_mem[r_clr_addr] <= '0;
        end else if (i_cmd.ins && can_store) begin
            bkt_mem[r_bucket] <= {1'b1, (r_hvalid ? r_head : new_node), new_node};
        end
        r_bkt_rd <= bkt_mem[r_bucket];
    end

    // node stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && can_store) key_mem[new_node] <= r_key;
        r_key_rd <= key_mem[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && can_store) begin
            link_mem[new_node] <= '0;
        end else if (i_cmd.link && r_append) begin
            link_mem[r_tail] <= {1'b1, r_nodes_used[NodeW-1:0] - NodeW'(1)};
        end
        r_link_rd <= link_mem[r_cur];
    end

    assign o_status.cnt_zero   = (r_cnt == '0);
    assign o_status.fold_done  = fold_done;
    assign o_status.clr_done   = (r_clr_addr == '1);
    assign o_status.bkt_valid  = r_bkt_rd[BktW-1];
    assign o_status.link_valid = r_link_rd[NodeW];
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
endmodule
`default_nettype wire

### design/hash_insert_distinct_chained_unit.sv
// top level of the chained hash insert unit
`default_nettype none
// Inserts one 31-bit key per request into a chained hash table of 2048
// buckets and 1024 nodes, keeping a key only if it is not already in its
// bucket's chain. The bucket is ((hash_mult*key + hash_add) mod 999149) mod
// num_slots, where num_slots of 0 acts as 1 and above 2048 acts as 2048.
// After reset the unit clears every entry of the bucket store and
// accepts no request then; configuration writes are taken at any time and
// should be made while idle. A request goes through one multiply, the
// reduction mod 999149 that folds the bits above the low 20 back in with a
// 32x16 multiply per cycle (0 to 9 folds, depending on the product's size)
// and finishes with one compare and subtract, a bit-serial reduction of
// that 20-bit remainder mod the bucket count, then a walk of the bucket's
// chain that reads each node through the registered node store read port,
// and finally the insert and the statistics.
// One request is worked on at a time; a result sits in an output register so
// a new request can be accepted while the previous result waits to be taken,
// and the last cycle stretches while an earlier result is still not taken.
module hash_insert_distinct_chained_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration
    input  wire                            i_cfg_we,
    input  wire  [1:0]                     i_cfg_idx,
    input  wire  [hidc_pkg::CfgW-1:0]      i_cfg_data,
    // request channel
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [hidc_pkg::KeyW-1:0]      i_key,
    // result channel
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [hidc_pkg::SlotW-1:0]     o_bucket,
    output logic                           o_inserted,
    output logic                           o_table_full,
    output logic [hidc_pkg::CntW-1:0]      o_chain_length,
    output logic [hidc_pkg::CntW-1:0]      o_collisions,
    output logic [hidc_pkg::CntW-1:0]      o_longest_chain,
    output logic [hidc_pkg::CntW-1:0]      o_stored_keys
);
    hidc_pkg::t_cmd    cmd;
    hidc_pkg::t_status status;

    // sequencer
    hidc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // hashing, stores and statistics
    hidc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_key           (i_key),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_bucket        (o_bucket),
        .o_inserted      (o_inserted),
        .o_table_full    (o_table_full),
        .o_chain_length  (o_chain_length),
        .o_collisions    (o_collisions),
        .o_longest_chain (o_longest_chain),
        .o_stored_keys   (o_stored_keys)
    );
endmodule
`default_nettype wire

### design/hidc_checker.sv
// port-level checks of the chained hash insert unit and their bind
`default_nettype none
`include "hash_insert_distinct_chained_unit_defines.svh"
module hidc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input wire                          o_inserted,
    input wire                          o_table_full,
    input wire [hidc_pkg::CntW-1:0]     o_chain_length,
    input wire [hidc_pkg::CntW-1:0]     o_collisions,
    input wire [hidc_pkg::CntW-1:0]     o_longest_chain,
    input wire [hidc_pkg::CntW-1:0]     o_stored_keys
);
    `HIDC_ASSERT_NEVER(a_ins_and_full, i_clk, i_rst_n, o_out_valid && o_inserted && o_table_full)
    `HIDC_ASSERT_IMPLY(a_ins_len, i_clk, i_rst_n, o_out_valid && o_inserted, o_chain_length != '0 && o_longest_chain >= o_chain_length)
    `HIDC_ASSERT_IMPLY(a_counts, i_clk, i_rst_n, o_out_valid, o_collisions <= o_stored_keys)
    `HIDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_stored_keys))
endmodule

bind hash_insert_distinct_chained_unit hidc_checker u_hidc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_inserted      (o_inserted),
    .o_table_full    (o_table_full),
    .o_chain_length  (o_chain_length),
    .o_collisions    (o_collisions),
    .o_longest_chain (o_longest_chain),
    .o_stored_keys   (o_stored_keys)
);
`default_nettype wire
